// ===== sv/dmsa_pkg.sv =====
// Shared types and fixed field widths for the difference mean/std accumulator.
package dmsa_pkg;

  // Fixed widths of the stream fields
  localparam int PIXEL_W = 8;
  localparam int MEAN_W  = 17;
  localparam int STD_W   = 16;
  localparam int COUNT_W = 17;

  // Operation of the shared adder/subtractor
  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } alu_op_e;

  // One result transaction
  typedef struct packed {
    logic               overflow;
    logic [COUNT_W-1:0] pair_count;
    logic [STD_W-1:0]   std_diff;
    logic [MEAN_W-1:0]  mean_diff;
  } dmsa_result_t;

endpackage

// ===== sv/dmsa_alu.sv =====
// Shared wide adder/subtractor with carry (no-borrow) out.
module dmsa_alu #(
  parameter int W = 8
) (
  input  dmsa_pkg::alu_op_e op_i,
  input  logic [W-1:0]      a_i,
  input  logic [W-1:0]      b_i,
  output logic [W-1:0]      sum_o,
  output logic              carry_o
);
  import dmsa_pkg::*;

  logic         sub_c;
  logic [W-1:0] b_eff_c;
  logic [W:0]   res_c;

  // a + b, or a - b as a + ~b + 1; on subtract carry high means a >= b
  assign sub_c   = (op_i == ALU_SUB);
  assign b_eff_c = sub_c ? ~b_i : b_i;
  assign res_c   = {1'b0, a_i} + {1'b0, b_eff_c} + (W+1)'(sub_c);
  assign sum_o   = res_c[W-1:0];
  assign carry_o = res_c[W];

endmodule

// ===== sv/dmsa_accum.sv =====
// Per-pair accumulator: difference sum, sum of squares, saturating pair count.
module dmsa_accum #(
  parameter int MAX_PIXELS = 65536,
  parameter int CW         = $clog2(MAX_PIXELS + 1),
  parameter int SW         = CW + 9,
  parameter int QW         = CW + 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            en_i,
  input  logic                            clear_i,
  input  logic [dmsa_pkg::PIXEL_W-1:0]    pixel_here_i,
  input  logic [dmsa_pkg::PIXEL_W-1:0]    pixel_displaced_i,
  output logic signed [SW-1:0]            sum_o,
  output logic [QW-1:0]                   sumsq_o,
  output logic [CW-1:0]                   count_o,
  output logic                            ovf_o
);
  import dmsa_pkg::*;

  logic signed [PIXEL_W:0]       diff_c;
  logic signed [2*PIXEL_W+1:0]   sq_full_c;
  logic [2*PIXEL_W-1:0]          sq_c;
  logic                          room_c;

  logic signed [SW-1:0] sum_q;
  logic [QW-1:0]        sumsq_q;
  logic [CW-1:0]        count_q;
  logic                 ovf_q;

  // Signed difference and its square (at most 255^2, fits 16 bits)
  assign diff_c    = $signed({1'b0, pixel_here_i}) - $signed({1'b0, pixel_displaced_i});
  assign sq_full_c = diff_c * diff_c;
  assign sq_c      = sq_full_c[2*PIXEL_W-1:0];
  assign room_c    = (count_q < CW'(MAX_PIXELS));

  // Running sums; pairs beyond the limit only raise the overflow flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q   <= '0;
      sumsq_q <= '0;
      count_q <= '0;
      ovf_q   <= 1'b0;
    end else if (clear_i) begin
      sum_q   <= '0;
      sumsq_q <= '0;
      count_q <= '0;
      ovf_q   <= 1'b0;
    end else if (en_i) begin
      if (room_c) begin
        sum_q   <= sum_q + SW'(diff_c);
        sumsq_q <= sumsq_q + QW'(sq_c);
        count_q <= count_q + CW'(1);
      end else begin
        ovf_q   <= 1'b1;
      end
    end
  end

  assign sum_o   = sum_q;
  assign sumsq_o = sumsq_q;
  assign count_o = count_q;
  assign ovf_o   = ovf_q;

endmodule

// ===== sv/difference_mean_std_accumulator.sv =====
// Top level: pair accumulator plus sequencer that runs mean, variance and root.
//
// Input stream (s_axis): one pixel pair per transaction; tlast marks the last
// pair of a box. Pairs without tlast are taken one per cycle and only update
// the running sums. After a pair with tlast, tready stays low while one shared
// adder/subtractor works through the result, one bit per cycle:
//   capture, mean divide, n*sumsq, minus sum^2, square root, root / n
//   and handoff, in that order.
// Output stream (m_axis): one result transaction per box, held in an output
// register. The next box can start streaming while that result waits; only a
// second result waits for the first to be taken, stalling the input.
// Mean and standard deviation are signed/unsigned fixed point with FRAC_BITS
// fraction bits, truncated. Once MAX_PIXELS pairs are counted, further pairs
// are dropped and the overflow flag is set in tuser.
// Reset clears all sums and counts and drops any pending result.
module difference_mean_std_accumulator #(
  parameter int MAX_PIXELS = 65536,
  parameter int FRAC_BITS  = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [7:0] pixel_here, [15:8] pixel_displaced
  input  logic        s_axis_tlast,   // last_pixel
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,   // [16:0] mean_diff, [32:17] std_diff,
                                      // [49:33] pair_count, [55:50] zero
  output logic        m_axis_tuser    // overflow
);
  import dmsa_pkg::*;

  localparam int CW   = $clog2(MAX_PIXELS + 1);
  localparam int SW   = CW + 9;
  localparam int QW   = CW + 16;
  localparam int MW   = CW + 8;
  localparam int DW   = CW + 8 + FRAC_BITS;
  localparam int XW   = 2 * DW;
  localparam int RW   = DW + 2;
  localparam int CNTW = $clog2(DW);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_PREP = 3'd1;
  localparam logic [2:0] ST_DIVM = 3'd2;
  localparam logic [2:0] ST_MULP = 3'd3;
  localparam logic [2:0] ST_MULM = 3'd4;
  localparam logic [2:0] ST_SQRT = 3'd5;
  localparam logic [2:0] ST_DIVS = 3'd6;
  localparam logic [2:0] ST_DONE = 3'd7;

  logic [2:0]      state_q;
  logic [CNTW-1:0] cnt_q;
  logic            m_valid_q;

  logic [XW-1:0]       acc_q;
  logic [XW-1:0]       mc_q;
  logic [MW-1:0]       mp_q;
  logic [RW-1:0]       rem_q;
  logic [DW-1:0]       dv_q;
  logic [MW-1:0]       mag_q;
  logic [CW-1:0]       n_q;
  logic                neg_q;
  logic                ovf_q;
  logic [MEAN_W-1:0]   mean_q;
  logic [STD_W-1:0]    std_q;
  dmsa_result_t        res_q;

  logic                 in_acc_c;
  logic                 out_load_c;
  logic                 last_step_c;
  logic signed [SW-1:0] acc_sum;
  logic [QW-1:0]        acc_sumsq;
  logic [CW-1:0]        acc_count;
  logic                 acc_ovf;

  logic [SW-1:0]      sum_u_c;
  logic               neg_c;
  logic [SW-1:0]      mag_full_c;
  logic [MW-1:0]      mag_c;
  logic [CW:0]        div_rem_c;
  logic [RW-1:0]      sq_rem_c;
  logic [RW-1:0]      sq_trial_c;
  logic [DW-1:0]      quot_c;
  logic [MEAN_W-1:0]  q_mean_c;
  logic [MEAN_W-1:0]  mean_c;

  alu_op_e       alu_op;
  logic [XW-1:0] alu_a;
  logic [XW-1:0] alu_b;
  logic [XW-1:0] alu_sum;
  logic          alu_carry;

  // Handshakes
  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc_c      = s_axis_tvalid && s_axis_tready;
  assign out_load_c    = (state_q == ST_DONE) && (!m_valid_q || m_axis_tready);
  assign last_step_c   = (cnt_q == '0);

  dmsa_accum #(
    .MAX_PIXELS (MAX_PIXELS),
    .CW         (CW),
    .SW         (SW),
    .QW         (QW)
  ) u_accum (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .en_i              (in_acc_c),
    .clear_i           (state_q == ST_PREP),
    .pixel_here_i      (s_axis_tdata[7:0]),
    .pixel_displaced_i (s_axis_tdata[15:8]),
    .sum_o             (acc_sum),
    .sumsq_o           (acc_sumsq),
    .count_o           (acc_count),
    .ovf_o             (acc_ovf)
  );

  // Magnitude and sign of the difference sum
  assign sum_u_c    = acc_sum;
  assign neg_c      = acc_sum[SW-1];
  assign mag_full_c = neg_c ? (~sum_u_c + SW'(1)) : sum_u_c;
  assign mag_c      = mag_full_c[MW-1:0];

  // Restoring divide step, restoring root step, quotient/root shift-in
  assign div_rem_c  = {rem_q[CW-1:0], dv_q[DW-1]};
  assign sq_rem_c   = {rem_q[RW-3:0], acc_q[XW-1 -: 2]};
  assign sq_trial_c = {dv_q, 2'b01};
  assign quot_c     = {dv_q[DW-2:0], alu_carry};

  // Signed mean from the quotient magnitude
  assign q_mean_c = MEAN_W'(quot_c);
  assign mean_c   = neg_q ? (~q_mean_c + MEAN_W'(1)) : q_mean_c;

  // Operand select for the shared unit
  always_comb begin
    alu_op = ALU_ADD;
    alu_a  = '0;
    alu_b  = '0;
    case (state_q)
      ST_DIVM, ST_DIVS: begin
        alu_op = ALU_SUB;
        alu_a  = XW'(div_rem_c);
        alu_b  = XW'(n_q);
      end
      ST_MULP: begin
        alu_op = ALU_ADD;
        alu_a  = acc_q;
        alu_b  = mp_q[0] ? mc_q : '0;
      end
      ST_MULM: begin
        alu_op = ALU_SUB;
        alu_a  = acc_q;
        alu_b  = mp_q[0] ? mc_q : '0;
      end
      ST_SQRT: begin
        alu_op = ALU_SUB;
        alu_a  = XW'(sq_rem_c);
        alu_b  = XW'(sq_trial_c);
      end
      default: begin
        alu_op = ALU_ADD;
        alu_a  = '0;
        alu_b  = '0;
      end
    endcase
  end

  dmsa_alu #(
    .W (XW)
  ) u_alu (
    .op_i    (alu_op),
    .a_i     (alu_a),
    .b_i     (alu_b),
    .sum_o   (alu_sum),
    .carry_o (alu_carry)
  );

  // Sequencer and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cnt_q     <= '0;
      m_valid_q <= 1'b0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (in_acc_c && s_axis_tlast) begin
            state_q <= ST_PREP;
          end
        end
        ST_PREP: begin
          state_q <= ST_DIVM;
          cnt_q   <= CNTW'(DW - 1);
        end
        ST_DIVM: begin
          if (last_step_c) begin
            state_q <= ST_MULP;
            cnt_q   <= CNTW'(CW - 1);
          end else begin
            cnt_q <= cnt_q - CNTW'(1);
          end
        end
        ST_MULP: begin
          if (last_step_c) begin
            state_q <= ST_MULM;
            cnt_q   <= CNTW'(MW - 1);
          end else begin
            cnt_q <= cnt_q - CNTW'(1);
          end
        end
        ST_MULM: begin
          if (last_step_c) begin
            state_q <= ST_SQRT;
            cnt_q   <= CNTW'(DW - 1);
          end else begin
            cnt_q <= cnt_q - CNTW'(1);
          end
        end
        ST_SQRT: begin
          if (last_step_c) begin
            state_q <= ST_DIVS;
            cnt_q   <= CNTW'(DW - 1);
          end else begin
            cnt_q <= cnt_q - CNTW'(1);
          end
        end
        ST_DIVS: begin
          if (last_step_c) begin
            state_q <= ST_DONE;
          end else begin
            cnt_q <= cnt_q - CNTW'(1);
          end
        end
        ST_DONE: begin
          if (out_load_c) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase

      if (out_load_c) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_PREP: begin
        // capture the box and start the mean divide on |sum| << FRAC_BITS
        neg_q <= neg_c;
        mag_q <= mag_c;
        n_q   <= acc_count;
        ovf_q <= acc_ovf;
        dv_q  <= DW'(mag_c) << FRAC_BITS;
        rem_q <= '0;
        acc_q <= '0;
        mc_q  <= XW'(acc_sumsq);
        mp_q  <= MW'(acc_count);
      end
      ST_DIVM, ST_DIVS: begin
        rem_q <= alu_carry ? RW'(alu_sum[CW:0]) : RW'(div_rem_c);
        dv_q  <= quot_c;
        if (last_step_c && (state_q == ST_DIVM)) begin
          mean_q <= mean_c;
        end
        if (last_step_c && (state_q == ST_DIVS)) begin
          std_q <= STD_W'(quot_c);
        end
      end
      ST_MULP: begin
        // shift-add n * sumsq, then load |sum| as both factors
        acc_q <= alu_sum;
        if (last_step_c) begin
          mc_q <= XW'(mag_q);
          mp_q <= mag_q;
        end else begin
          mc_q <= mc_q << 1;
          mp_q <= mp_q >> 1;
        end
      end
      ST_MULM: begin
        // shift-subtract sum^2; the variance numerator then gets 2*FRAC_BITS
        mc_q <= mc_q << 1;
        mp_q <= mp_q >> 1;
        if (last_step_c) begin
          acc_q <= alu_sum << (2 * FRAC_BITS);
          rem_q <= '0;
          dv_q  <= '0;
        end else begin
          acc_q <= alu_sum;
        end
      end
      ST_SQRT: begin
        // two radicand bits per step, one root bit into dv
        dv_q  <= quot_c;
        acc_q <= acc_q << 2;
        if (last_step_c) begin
          rem_q <= '0;
        end else begin
          rem_q <= alu_carry ? alu_sum[RW-1:0] : sq_rem_c;
        end
      end
      default: begin
      end
    endcase

    if (out_load_c) begin
      res_q.overflow   <= ovf_q;
      res_q.pair_count <= COUNT_W'(n_q);
      res_q.std_diff   <= std_q;
      res_q.mean_diff  <= mean_q;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {6'b0, res_q.pair_count, res_q.std_diff, res_q.mean_diff};
  assign m_axis_tuser  = res_q.overflow;

  // The sum^2 subtraction never drives the variance numerator below zero
  a_var_no_borrow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MULM && mp_q[0]) |-> alu_carry)
    else $error("variance numerator went negative");

  // Division remainder stays below the pair count
  a_div_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIVM || state_q == ST_DIVS) |-> (rem_q < RW'(n_q)))
    else $error("divider remainder not below pair count");

  // A last pair closes the input until the result is handed off
  a_last_closes_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && s_axis_tlast) |=> !s_axis_tready)
    else $error("input still open after last pair");

endmodule
